/* hw/rtl/lru_cache_access_cost_macros.svh */
// Assertion macros shared by the LRU cache access cost RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LRU_CACHE_ACCESS_COST_MACROS_SVH
`define LRU_CACHE_ACCESS_COST_MACROS_SVH

// Checked on every clock edge outside reset.
`define LCA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LCA_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/lca_pkg.sv */
// Shared constants, types and the case-folding function of the LRU cache.
// No dependencies; imported by the top level, by lca_age_bank and by the testbench.
package lca_pkg;

   localparam int MAX_WAYS = 32;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W    = $clog2(MAX_WAYS + 1);
   localparam int AGE_W    = 6;
   localparam int CSR_W    = 6;
   localparam int COST_W   = 3;
   localparam int TOTAL_W  = 32;
   localparam int LO_W     = 64;
   localparam int MID_W    = 64;
   localparam int HI_W     = 32;
   localparam int NAME_W   = LO_W + MID_W + HI_W;

   localparam int REQ_TDATA_W = ((NAME_W + 7) / 8) * 8;
   localparam int RSP_BITS    = COST_W + TOTAL_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   localparam logic [AGE_W-1:0]  AGE_MAX   = '1;
   localparam logic [COST_W-1:0] HIT_COST  = 3'd1;
   localparam logic [COST_W-1:0] MISS_COST = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_UPD  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   // Recency update request for the age bank
   typedef struct packed {
      logic             update;   // apply this cycle
      logic             fill;     // slot becomes valid (miss)
      logic [WAY_W-1:0] slot;     // way made most recent
      logic             limit_en; // age only ways younger than limit (hit)
      logic [AGE_W-1:0] limit;
      logic [CNT_W-1:0] ways;     // ways in use
   } age_ctrl_type;

   // Fold a..z to upper case, bytewise; all other bytes pass unchanged
   function automatic logic [63:0] fold_word(input logic [63:0] w);
      logic [63:0] r;
      logic [7:0]  c;
      r = '0;
      for (int b = 0; b < 8; b++) begin
         c = w[8*b +: 8];
         if (c inside {[8'h61:8'h7A]}) c = c - 8'h20;
         r[8*b +: 8] = c;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/lru_cache_access_cost.sv */
// Top level of the LRU cache; uses lca_pkg, lca_ram, lca_age_bank and the macros header.
// Each accepted word passes through the states SCAN, UPD and OUT before its result is
// registered; ways = min(cache_size, MAX_WAYS), and SCAN reads no tag when it is zero.
// A new word is taken only in IDLE, after the previous result has left OUT; the tag scan
// reads one way per cycle through the single read port of the tag RAM.
// Reset (synchronous): clears valid bits, ages, total and cache_size; tags are kept.
`include "lru_cache_access_cost_macros.svh"

module lru_cache_access_cost (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: name_chars_lo [63:0], name_chars_mid [127:64], name_chars_hi [159:128]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lca_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: access_cost [2:0], running_total [34:3], zero pad above
   // rsp_tuser: hit [0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lca_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]                      rsp_tuser,
   // csr_data: cache_size [5:0]
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lca_pkg::CSR_W-1:0]       csr_data
);
   import lca_pkg::*;

   // ---------------------------------------------------------------
   // Configuration: always ready; unchecked, so the user must write it only while idle
   // ---------------------------------------------------------------
   logic [CSR_W-1:0] size_ff;
   logic [CNT_W-1:0] ways;
   logic [6:0]       size_wide;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)          size_ff <= '0;
      else if (csr_valid) size_ff <= csr_data;
   end

   // Ways in use, clamped to the build size
   always_comb begin
      size_wide = 7'(size_ff);
      if (size_wide > 7'(MAX_WAYS)) ways = CNT_W'(MAX_WAYS);
      else                          ways = CNT_W'(size_wide);
   end

   // ---------------------------------------------------------------
   // Name folding at the input
   // ---------------------------------------------------------------
   logic [LO_W-1:0]   lo_fold, mid_fold;
   logic [63:0]       hi_fold_full;
   logic [NAME_W-1:0] name_fold;

   assign lo_fold      = fold_word(req_tdata[LO_W-1:0]);
   assign mid_fold     = fold_word(req_tdata[LO_W+MID_W-1:LO_W]);
   assign hi_fold_full = fold_word({32'h0, req_tdata[NAME_W-1:LO_W+MID_W]});
   assign name_fold    = {hi_fold_full[HI_W-1:0], mid_fold, lo_fold};

   // ---------------------------------------------------------------
   // Control and scan state
   // ---------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;         // next way to read
   logic              cmp_v_ff, cmp_v_in;     // read data returning this cycle
   logic [WAY_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              hit_ff, hit_in;
   logic [WAY_W-1:0]  hit_way_ff, hit_way_in;
   logic [AGE_W-1:0]  hit_age_ff, hit_age_in;
   logic              free_v_ff, free_v_in;   // lowest invalid way seen
   logic [WAY_W-1:0]  free_way_ff, free_way_in;
   logic              old_v_ff, old_v_in;     // oldest way seen, lowest on ties
   logic [WAY_W-1:0]  old_way_ff, old_way_in;
   logic [AGE_W-1:0]  old_age_ff, old_age_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // Output register
   logic               rsp_v_ff, rsp_v_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [COST_W-1:0]  rsp_cost_ff, rsp_cost_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   // Memory and age bank hooks
   logic               ram_re, ram_we;
   logic [WAY_W-1:0]   ram_raddr, slot;
   logic [NAME_W-1:0]  ram_rdata;
   logic               rd_valid;
   logic [AGE_W-1:0]   rd_age;
   age_ctrl_type       age_ctrl;

   logic               req_acc;
   logic [COST_W-1:0]  cost;
   logic [TOTAL_W:0]   total_sum;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // Victim choice: hit way, else lowest free way, else oldest
   assign slot = hit_ff ? hit_way_ff : (free_v_ff ? free_way_ff : old_way_ff);
   assign cost = hit_ff ? HIT_COST : MISS_COST;
   assign total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(cost);

   // Tag RAM is written only in UPD and read only in SCAN, so a new scan
   // always sees the previous item's fill without forwarding.
   assign ram_raddr = idx_ff[WAY_W-1:0];
   assign ram_we    = (state_ff == ST_UPD) && !hit_ff && (ways != '0);

   always_comb begin
      age_ctrl.update   = (state_ff == ST_UPD) && (ways != '0);
      age_ctrl.fill     = !hit_ff;
      age_ctrl.slot     = slot;
      age_ctrl.limit_en = hit_ff;
      age_ctrl.limit    = hit_age_ff;
      age_ctrl.ways     = ways;
   end

   always_comb begin
      state_in    = state_ff;
      name_in     = name_ff;
      idx_in      = idx_ff;
      cmp_v_in    = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      hit_in      = hit_ff;
      hit_way_in  = hit_way_ff;
      hit_age_in  = hit_age_ff;
      free_v_in   = free_v_ff;
      free_way_in = free_way_ff;
      old_v_in    = old_v_ff;
      old_way_in  = old_way_ff;
      old_age_in  = old_age_ff;
      total_in    = total_ff;
      ram_re      = 1'b0;

      rsp_v_in     = rsp_v_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_total_in = rsp_total_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               name_in   = name_fold;
               idx_in    = '0;
               hit_in    = 1'b0;
               free_v_in = 1'b0;
               old_v_in  = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one tag read per cycle
            if (idx_ff < ways) begin
               ram_re     = 1'b1;
               idx_in     = idx_ff + 1'b1;
               cmp_v_in   = 1'b1;
               cmp_idx_in = idx_ff[WAY_W-1:0];
            end
            if (ways == '0) begin
               state_in = ST_UPD;
            end else if (cmp_v_ff) begin
               if (rd_valid && ram_rdata == name_ff) begin
                  hit_in     = 1'b1;
                  hit_way_in = cmp_idx_ff;
                  hit_age_in = rd_age;
                  state_in   = ST_UPD;
               end else begin
                  if (!rd_valid && !free_v_ff) begin
                     free_v_in   = 1'b1;
                     free_way_in = cmp_idx_ff;
                  end
                  if (!old_v_ff || rd_age > old_age_ff) begin
                     old_v_in   = 1'b1;
                     old_way_in = cmp_idx_ff;
                     old_age_in = rd_age;
                  end
                  if (CNT_W'(cmp_idx_ff) + 1'b1 == ways) state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in     = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_cost_in  = cost;
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmp_v_ff <= 1'b0;
         total_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmp_v_ff <= cmp_v_in;
         total_ff <= total_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff      <= name_in;
      idx_ff       <= idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      hit_way_ff   <= hit_way_in;
      hit_age_ff   <= hit_age_in;
      free_v_ff    <= free_v_in;
      free_way_ff  <= free_way_in;
      old_v_ff     <= old_v_in;
      old_way_ff   <= old_way_in;
      old_age_ff   <= old_age_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_total_ff <= rsp_total_in;
   end

   // ---------------------------------------------------------------
   // Storage
   // ---------------------------------------------------------------
   lca_ram #(
      .WIDTH (NAME_W),
      .DEPTH (MAX_WAYS)
   ) u_tag_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot),
      .wdata (name_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Valid and age read at the way whose tag is being compared
   lca_age_bank u_age_bank (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (age_ctrl),
      .rd_idx   (cmp_idx_ff),
      .rd_valid (rd_valid),
      .rd_age   (rd_age)
   );

   // ---------------------------------------------------------------
   // Result channel
   // ---------------------------------------------------------------
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_total_ff, rsp_cost_ff};
   assign rsp_tuser  = rsp_hit_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `LCA_ASSERT(a_cost_matches_hit, rsp_v_ff |-> (rsp_hit_ff ? (rsp_cost_ff == HIT_COST) : (rsp_cost_ff == MISS_COST)), "cost disagrees with hit flag")
   `LCA_ASSERT(a_total_no_wrap, (state_ff == ST_UPD) |=> (total_ff >= $past(total_ff)), "running total went down")
   `LCA_ASSERT(a_hit_in_use, (state_ff == ST_UPD && hit_ff) |-> (CNT_W'(hit_way_ff) < ways), "hit outside ways in use")
   `LCA_ASSERT_RST(a_reset_idle, reset |=> (!rsp_v_ff && state_ff == ST_IDLE), "not idle after reset")

endmodule

/* hw/rtl/lca_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/lca_age_bank.sv */
// Valid bits and recency ages of all ways, with the parallel aging update.
// Depends on lca_pkg.
module lca_age_bank (
   input  logic                        clock,
   input  logic                        reset,
   input  lca_pkg::age_ctrl_type       ctrl,
   input  logic [lca_pkg::WAY_W-1:0]   rd_idx,
   output logic                        rd_valid,
   output logic [lca_pkg::AGE_W-1:0]   rd_age
);
   import lca_pkg::*;

   logic             valid_ff [MAX_WAYS];
   logic [AGE_W-1:0] age_ff   [MAX_WAYS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WAYS; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
      end else if (ctrl.update) begin
         for (int i = 0; i < MAX_WAYS; i++) begin
            if (WAY_W'(i) == ctrl.slot) begin
               age_ff[i] <= '0;
               if (ctrl.fill) valid_ff[i] <= 1'b1;
            end else if (CNT_W'(i) < ctrl.ways && valid_ff[i] &&
                         (!ctrl.limit_en || age_ff[i] < ctrl.limit) &&
                         age_ff[i] != AGE_MAX) begin
               age_ff[i] <= age_ff[i] + 1'b1;
            end
         end
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_age   = age_ff[rd_idx];

endmodule

/* dv/lru_cost_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the LRU cache access cost block: watches the three channels,
// predicts each response word and compares it field by field. Depends on lca_pkg.
module lru_cost_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lca_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [lca_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [0:0]                      rsp_tuser,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [lca_pkg::CSR_W-1:0]       csr_data,
   output int unsigned                     mismatch_count,
   output int unsigned                     outstanding,
   output int unsigned                     hits_seen,
   output int unsigned                     words_checked
);
   import lca_pkg::*;

   typedef struct packed {
      logic               hit;
      logic [COST_W-1:0]  cost;
      logic [TOTAL_W-1:0] total;
   } access_outcome_type;

   // shadow copy of the cache
   logic [NAME_W-1:0]  tag_store  [MAX_WAYS];
   logic               entry_live [MAX_WAYS];
   logic [AGE_W-1:0]   age_rank   [MAX_WAYS];
   logic [TOTAL_W-1:0] cost_sum;
   logic [CSR_W-1:0]   size_reg;

   access_outcome_type outcome_q [$];
   int unsigned        fails, hits, checked;

   initial begin
      fails   = 0;
      hits    = 0;
      checked = 0;
   end

   // age every live way in use below the limit, saturating; self becomes newest
   task automatic age_others(input int ways, input int self, input int limit);
      for (int i = 0; i < ways; i++) begin
         if (i != self && entry_live[i] && age_rank[i] < limit && age_rank[i] != AGE_MAX)
            age_rank[i] = age_rank[i] + 1'b1;
      end
      age_rank[self] = '0;
   endtask

   task automatic predict_access(input logic [NAME_W-1:0] raw,
                                 output access_outcome_type res);
      logic [NAME_W-1:0]  key;
      logic [7:0]         c;
      logic [TOTAL_W:0]   sum;
      int                 ways, slot;
      bit                 found;
      for (int b = 0; b < NAME_W / 8; b++) begin
         c = raw[8*b +: 8];
         if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
         key[8*b +: 8] = c;
      end
      ways  = (size_reg > MAX_WAYS) ? MAX_WAYS : int'(size_reg);
      found = 1'b0;
      slot  = 0;
      for (int i = 0; i < ways; i++) begin
         if (!found && entry_live[i] && tag_store[i] == key) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (found) begin
         age_others(ways, slot, age_rank[slot]);
      end else if (ways > 0) begin
         slot = ways;
         for (int i = 0; i < ways; i++)
            if (slot == ways && !entry_live[i]) slot = i;
         if (slot == ways) begin
            // oldest wins, lowest way on a tie
            slot = 0;
            for (int i = 1; i < ways; i++)
               if (age_rank[i] > age_rank[slot]) slot = i;
         end
         tag_store[slot]  = key;
         entry_live[slot] = 1'b1;
         age_others(ways, slot, 64);
      end
      res.hit  = found;
      res.cost = found ? HIT_COST : MISS_COST;
      sum      = {1'b0, cost_sum} + res.cost;
      cost_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      res.total = cost_sum;
   endtask

   always @(posedge clock) begin
      access_outcome_type   want;
      logic [COST_W-1:0]    got_cost;
      logic [TOTAL_W-1:0]   got_total;
      logic [RSP_PAD_W-1:0] got_pad;
      if (reset) begin
         for (int i = 0; i < MAX_WAYS; i++) begin
            entry_live[i] = 1'b0;
            age_rank[i]   = '0;
         end
         cost_sum = '0;
         size_reg = '0;
         outcome_q.delete();
      end else begin
         if (csr_valid && csr_ready) size_reg = csr_data;
         // response first: a word landing this edge belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            got_cost  = rsp_tdata[COST_W-1:0];
            got_total = rsp_tdata[COST_W +: TOTAL_W];
            got_pad   = rsp_tdata[RSP_TDATA_W-1:RSP_BITS];
            checked++;
            if (rsp_tuser[0]) hits++;
            if (outcome_q.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("[%0t] unexpected response word: hit %0b cost %0d total %0d",
                           $realtime, rsp_tuser[0], got_cost, got_total);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tuser[0] !== want.hit || got_cost !== want.cost ||
                   got_total !== want.total || got_pad !== '0) begin
                  fails++;
                  if (fails <= 10)
                     $display("[%0t] mismatch: exp hit %0b cost %0d total %0d, got hit %0b cost %0d total %0d pad %h",
                              $realtime, want.hit, want.cost, want.total,
                              rsp_tuser[0], got_cost, got_total, got_pad);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_access(req_tdata, want);
            outcome_q.insert(outcome_q.size(), want);
         end
      end
      mismatch_count <= fails;
      outstanding    <= outcome_q.size();
      hits_seen      <= hits;
      words_checked  <= checked;
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the LRU cache access cost testbench: clock, reset, stimulus and verdict.
// Depends on lca_pkg, the block itself and lru_cost_checker.
module tb_top;
   import lca_pkg::*;

   typedef logic [REQ_TDATA_W-1:0] name_type;

   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int WATCHDOG    = 5000;  // cycles with no handshake at all
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 134;
   localparam int POOL        = 64;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   name_type           req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]         rsp_tuser;
   logic               csr_valid;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_data;

   int unsigned mismatch_count, outstanding, hits_seen, words_checked;

   // cache sizes visited by the random part: grow, shrink, off, beyond the way count
   int unsigned size_plan [PHASES] = '{1, 32, 5, 0, 63, 17, 2, 33, 8, 31, 3, 12, 40, 24};

   name_type    name_pool [POOL];
   bit          req_burst, rsp_burst;   // stretches with no idling
   bit          hold_pending;           // asks the receiver for one long hold-off
   int unsigned names_sent, idle_cycles;

   lru_cache_access_cost DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   lru_cost_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .hits_seen      (hits_seen),
      .words_checked  (words_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Name from text; char k lands in byte k, so lo/mid/hi pack naturally
   function automatic name_type text_name(input string s);
      name_type n;
      n = '0;
      for (int k = 0; k < s.len() && k < 20; k++) n[8*k +: 8] = s[k];
      return n;
   endfunction

   // Random name of 0..20 bytes: mostly letters, some printable, some any byte
   function automatic name_type random_name();
      name_type n;
      int       len, pick;
      n   = '0;
      len = $urandom_range(0, 20);
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            n[8*k +: 8] = 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
         else if (pick < 85)
            n[8*k +: 8] = 8'($urandom_range(8'h20, 8'h7F));
         else
            n[8*k +: 8] = 8'($urandom_range(0, 255));
      end
      return n;
   endfunction

   // Flip the case of random letters so that a hit must survive case folding
   function automatic name_type vary_case(input name_type n);
      logic [7:0] c;
      for (int k = 0; k < REQ_TDATA_W / 8; k++) begin
         c = n[8*k +: 8] | 8'h20;
         if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
            n[8*k +: 8] = n[8*k +: 8] ^ 8'h20;
      end
      return n;
   endfunction

   // Offer one request word after a random gap; tvalid stays up if the next word follows at once
   task automatic send_word(input name_type d);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      names_sent++;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
   endtask

   // Drop tvalid, wait for every response, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // cache_size is only written with the block idle
   task automatic write_size(input logic [CSR_W-1:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int       ways, pool_used;
      name_type d;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      req_burst    = 1'b0;
      hold_pending = 1'b0;
      names_sent   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // cache off after reset: every access a miss, extreme names included
      send_word('0);
      send_word('1);
      send_word(text_name("abc"));

      // four ways: fill, case-folded hit, zero name, high bytes, LRU eviction
      write_size(6'd4);
      send_word(text_name("alpha"));
      send_word(text_name("BETA"));
      send_word(text_name("AlPhA"));
      send_word('0);
      send_word(name_type'(160'hFF80E1));       // 0xE1 is not a letter, no folding
      send_word(name_type'(160'hFF80C1));       // must not match the one above
      send_word(text_name("beta"));
      send_word(text_name("alpha"));
      // letter boundaries: '`' '{' '@' '[' stay, 'a'..'z' fold
      send_word(text_name("`{az"));
      send_word(text_name("@[AZ"));
      send_word(text_name("`{AZ"));
      send_word(text_name("abcdefghijklmnopqrst"));   // full 20 chars across lo/mid/hi
      send_word(text_name("ABCDEFGHIJKLMNOPQRSt"));

      // register beyond the way count, then shrink: upper ways keep their contents
      write_size(6'd63);
      send_word(text_name("alpha"));
      send_word('1);
      send_word('1);
      write_size(6'd1);
      send_word(text_name("beta"));
      send_word(text_name("alpha"));
      send_word(text_name("Alpha"));

      // random part: a name pool per phase sized around the way count so hits are common
      for (int i = 0; i < POOL; i++) name_pool[i] = random_name();
      for (int p = 0; p < PHASES; p++) begin
         write_size(CSR_W'(size_plan[p]));
         ways      = (size_plan[p] > MAX_WAYS) ? MAX_WAYS : int'(size_plan[p]);
         pool_used = ways + ways / 2 + 2;
         if (pool_used > POOL) pool_used = POOL;
         // refresh part of the pool, the rest may still hit stale entries
         for (int i = 0; i < pool_used; i++)
            if ($urandom_range(0, 2) == 0) name_pool[i] = random_name();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 40) hold_pending = 1'b1;
            if ($urandom_range(0, 9) == 0)
               d = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            else
               d = vary_case(name_pool[$urandom_range(0, pool_used - 1)]);
            send_word(d);
         end
      end

      wait_drained();
      $display("covered %0d names over %0d cache size settings (off, 1 to 63, shrink and regrow)",
               names_sent, PHASES + 4);
      $display("%0d response words checked, %0d hits, %0d misses",
               words_checked, hits_seen, words_checked - hits_seen);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall per word, bursts without stalls, one long hold-off
   // ---------------------------------------------------------------------
   initial begin
      int stall;
      rsp_tready = 1'b0;
      rsp_burst  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 7);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall        = HOLD_CYCLES;   // sender keeps offering, block backs up
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: no word on any channel for too long
   // ---------------------------------------------------------------------
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG);
         $display("simulation failed");
         $finish;
      end
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/lca_pkg.sv
hw/rtl/lca_ram.sv
hw/rtl/lca_age_bank.sv
hw/rtl/lru_cache_access_cost.sv
dv/lru_cost_checker.sv
dv/tb_top.sv
